[sv/fsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and lookup tables of the ignition sequencer.
package fsc_pkg;

    localparam int CHANNELS   = 4;
    localparam int TIME_WIDTH = 32;

    // configuration register indexes
    localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
    localparam logic [2:0] REG_SHORT_PULSE = 3'd2;
    localparam logic [2:0] REG_LONG_PULSE  = 3'd3;
    localparam logic [2:0] REG_SHORT_FLASH = 3'd4;
    localparam logic [2:0] REG_LONG_FLASH  = 3'd5;

    // firing modes
    localparam logic [3:0] M_EDGE       = 4'd0;
    localparam logic [3:0] M_DELAY_A    = 4'd1;
    localparam logic [3:0] M_DELAY_B    = 4'd2;
    localparam logic [3:0] M_DELAY_C    = 4'd3;
    localparam logic [3:0] M_CHAIN_ONE  = 4'd4;
    localparam logic [3:0] M_CHAIN_PAIR = 4'd5;
    localparam logic [3:0] M_CHAIN_SER  = 4'd6;
    localparam logic [3:0] M_WINDOW     = 4'd7;
    localparam logic [3:0] M_SERIES_A   = 4'd8;
    localparam logic [3:0] M_SERIES_B   = 4'd9;
    localparam logic [3:0] M_SERIES_C   = 4'd10;
    localparam logic [3:0] M_RELAY      = 4'd11;
    localparam logic [3:0] M_COUNT      = 4'd12;
    localparam logic [3:0] M_MARK       = 4'd13;
    localparam logic [3:0] M_SWEEP      = 4'd14;
    localparam logic [3:0] M_LAST       = 4'd14;

    localparam logic [15:0] WINDOW_TICKS = 16'd200;
    localparam logic [15:0] COUNT_MATCH  = 16'd13;

    localparam logic [15:0] DELAY_A = 16'd200;
    localparam logic [15:0] DELAY_B = 16'd800;
    localparam logic [15:0] DELAY_C = 16'd2000;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READY = 2'd1,
        ST_FIRE  = 2'd2
    } t_chan_st;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [15:0] short_pulse_ticks;
        logic [15:0] long_pulse_ticks;
        logic [15:0] short_flash_ticks;
        logic [15:0] long_flash_ticks;
    } t_cfg;

    typedef struct packed {
        logic       enc_a;
        logic       enc_b;
        logic       button;
        logic [3:0] trigger_in;
    } t_req;

    typedef struct packed {
        logic [3:0] fire_out;
        logic [3:0] led_out;
        logic       is_armed;
        logic [3:0] mode_now;
        logic       long_mode;
    } t_res;

    // bit-reversed (mode + 1)
    function automatic logic [3:0] led_pattern(input logic [3:0] m);
        logic [3:0] r;
        r = 4'd0;
        if (m <= M_LAST) begin
            r = {m[0] ^ 1'b1, 3'b0};
            r = {(m + 4'd1)} ;
            r = {r[0], r[1], r[2], r[3]};
        end
        return r;
    endfunction

    // series offsets, row by mode 8..10, column by channel 1..3
    function automatic logic [15:0] series_at(input logic [1:0] row, input logic [1:0] col);
        logic [15:0] r;
        r = 16'd0;
        case ({row, col})
            4'b00_00: r = 16'd400;
            4'b00_01: r = 16'd800;
            4'b00_10: r = 16'd1000;
            4'b01_00: r = 16'd800;
            4'b01_01: r = 16'd1600;
            4'b01_10: r = 16'd2400;
            4'b10_00: r = 16'd2000;
            4'b10_01: r = 16'd4000;
            4'b10_10: r = 16'd6000;
            default:  r = 16'd0;
        endcase
        return r;
    endfunction

    // sweep start times, channel n fires at 2000 * (n + 1)
    function automatic logic [15:0] sweep_at(input logic [1:0] ch);
        logic [15:0] r;
        case (ch)
            2'd0:    r = 16'd2000;
            2'd1:    r = 16'd4000;
            2'd2:    r = 16'd6000;
            default: r = 16'd8000;
        endcase
        return r;
    endfunction

endpackage

[sv/fsc_core.sv]
`timescale 1ns / 1ps
// Tick state machine: encoder, button, flash, firing modes and ignition.
module fsc_core #(
    parameter int TIME_WIDTH = fsc_pkg::TIME_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  fsc_pkg::t_req i_req,
    input  fsc_pkg::t_cfg i_cfg,
    output fsc_pkg::t_res o_res
);

    localparam int TW = TIME_WIDTH;

    logic                  r_enc_last, n_enc_last;
    logic [3:0]            r_mode, n_mode;
    logic                  r_armed, n_armed;
    logic                  r_press, n_press;
    logic [15:0]           r_rel_cnt, n_rel_cnt;
    logic [15:0]           r_prs_cnt, n_prs_cnt;
    logic                  r_short, n_short;
    logic [15:0]           r_fl_cnt, n_fl_cnt;
    logic                  r_fl_ph, n_fl_ph;
    logic                  r_idle, n_idle;
    logic [2:0]            r_win, n_win;
    logic [TW-1:0]         r_gticks, n_gticks;
    logic [3:0]            r_trig, n_trig;
    fsc_pkg::t_chan_st     r_st [4];
    fsc_pkg::t_chan_st     n_st [4];
    logic [3:0]            r_en, n_en;
    logic [3:0]            r_pr, n_pr;
    logic [TW-1:0]         r_time [4];
    logic [TW-1:0]         n_time [4];
    logic [TW-1:0]         r_mark [4];
    logic [TW-1:0]         n_mark [4];
    logic [15:0]           r_pcnt [4];
    logic [15:0]           n_pcnt [4];
    logic [3:0]            r_q, n_q;
    logic [1:0]            r_fifo [4];
    logic [1:0]            n_fifo [4];
    logic [1:0]            r_head, n_head;
    logic [1:0]            r_tail, n_tail;
    logic [2:0]            r_cnt, n_cnt;
    logic [3:0]            r_fire, n_fire;
    logic [3:0]            led;

    function automatic logic [TW-1:0] tinc(input logic [TW-1:0] v);
        return (v == {TW{1'b1}}) ? v : v + 1'b1;
    endfunction

    always_comb begin
        logic [3:0]    e;
        logic [15:0]   plen;
        logic [15:0]   flen;
        logic [1:0]    src;
        logic          src_ok;
        logic          ok;
        logic [TW-1:0] d;
        logic [1:0]    y;

        n_enc_last = r_enc_last;
        n_mode     = r_mode;
        n_armed    = r_armed;
        n_press    = r_press;
        n_rel_cnt  = r_rel_cnt;
        n_prs_cnt  = r_prs_cnt;
        n_short    = r_short;
        n_fl_cnt   = r_fl_cnt;
        n_fl_ph    = r_fl_ph;
        n_idle     = r_idle;
        n_win      = r_win;
        n_gticks   = r_gticks;
        n_trig     = r_trig;
        n_en       = r_en;
        n_pr       = r_pr;
        n_q        = r_q;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        n_fire     = r_fire;
        for (int x = 0; x < 4; x++) begin
            n_st[x]   = r_st[x];
            n_time[x] = r_time[x];
            n_mark[x] = r_mark[x];
            n_pcnt[x] = r_pcnt[x];
            n_fifo[x] = r_fifo[x];
        end
        e      = i_req.trigger_in & ~r_trig;
        src    = 2'd0;
        src_ok = 1'b0;
        ok     = 1'b1;
        d      = '0;
        y      = 2'd0;

        // encoder, only while disarmed
        if (!r_armed) begin
            if (r_enc_last && !i_req.enc_a) begin
                if (i_req.enc_b)
                    n_mode = (r_mode >= fsc_pkg::M_LAST) ? fsc_pkg::M_EDGE : r_mode + 4'd1;
                else
                    n_mode = (r_mode == fsc_pkg::M_EDGE || r_mode > fsc_pkg::M_LAST) ?
                             fsc_pkg::M_LAST : r_mode - 4'd1;
            end
            n_enc_last = i_req.enc_a;
        end

        // button debounce, arming and disarming
        if (i_req.button && n_rel_cnt > {8'd0, i_cfg.debounce_ticks}) begin
            n_press   = 1'b1;
            n_rel_cnt = 16'd0;
        end
        if (n_press && n_prs_cnt != 16'hFFFF)
            n_prs_cnt = n_prs_cnt + 16'd1;
        if (n_press && n_rel_cnt > {8'd0, i_cfg.debounce_ticks}) begin
            n_rel_cnt = 16'd0;
            n_press   = 1'b0;
            n_armed   = ~n_armed;
            if (n_armed) begin
                n_en    = 4'hF;
                n_short = !(n_prs_cnt > i_cfg.long_press_ticks);
            end
            n_prs_cnt = 16'd0;
        end
        if (!n_armed) begin
            for (int x = 0; x < 4; x++) begin
                n_st[x]   = fsc_pkg::ST_IDLE;
                n_pcnt[x] = 16'd0;
                n_time[x] = '0;
                n_mark[x] = '0;
            end
            n_q      = 4'd0;
            n_pr     = 4'd0;
            n_en     = 4'd0;
            n_head   = 2'd0;
            n_tail   = 2'd3;
            n_cnt    = 3'd0;
            n_idle   = 1'b1;
            n_win    = 3'd0;
            n_gticks = '0;
            n_fire   = 4'd0;
        end
        if (!i_req.button && n_rel_cnt != 16'hFFFF)
            n_rel_cnt = n_rel_cnt + 16'd1;

        plen = n_short ? i_cfg.short_pulse_ticks : i_cfg.long_pulse_ticks;
        flen = n_short ? i_cfg.short_flash_ticks : i_cfg.long_flash_ticks;
        led  = fsc_pkg::led_pattern(n_mode);

        if (n_armed) begin
            if (n_fl_cnt != 16'hFFFF)
                n_fl_cnt = n_fl_cnt + 16'd1;
            if (n_fl_cnt > flen) begin
                n_fl_ph  = ~n_fl_ph;
                n_fl_cnt = 16'd0;
            end
            if (!n_fl_ph)
                led = 4'd0;

            case (n_mode)
                fsc_pkg::M_EDGE, fsc_pkg::M_COUNT: begin
                    for (int x = 0; x < 4; x++) begin
                        if (n_en[x] && e[x] && n_st[x] == fsc_pkg::ST_IDLE) begin
                            if (n_mode == fsc_pkg::M_EDGE) begin
                                n_st[x] = fsc_pkg::ST_READY;
                            end else begin
                                n_time[x] = tinc(n_time[x]);
                                if (n_time[x] == TW'(fsc_pkg::COUNT_MATCH))
                                    n_st[x] = fsc_pkg::ST_READY;
                            end
                        end
                    end
                    n_trig = i_req.trigger_in;
                end
                fsc_pkg::M_DELAY_A, fsc_pkg::M_DELAY_B, fsc_pkg::M_DELAY_C: begin
                    for (int x = 0; x < 4; x++) begin
                        if (n_en[x] && e[x] && !n_pr[x]) begin
                            n_time[x] = '0;
                            n_pr[x]   = 1'b1;
                        end
                        if (n_pr[x] && n_en[x] && n_st[x] == fsc_pkg::ST_IDLE) begin
                            n_time[x] = tinc(n_time[x]);
                            if ((n_mode == fsc_pkg::M_DELAY_A &&
                                 n_time[x] > TW'(fsc_pkg::DELAY_A)) ||
                                (n_mode == fsc_pkg::M_DELAY_B &&
                                 n_time[x] > TW'(fsc_pkg::DELAY_B)) ||
                                (n_mode == fsc_pkg::M_DELAY_C &&
                                 n_time[x] > TW'(fsc_pkg::DELAY_C))) begin
                                n_st[x] = fsc_pkg::ST_READY;
                                n_pr[x] = 1'b0;
                            end
                        end
                    end
                    n_trig = i_req.trigger_in;
                end
                fsc_pkg::M_CHAIN_ONE, fsc_pkg::M_CHAIN_PAIR, fsc_pkg::M_CHAIN_SER: begin
                    if (e[0] && !n_pr[0] && n_st[0] == fsc_pkg::ST_IDLE) begin
                        n_pr[0] = 1'b1;
                        n_st[0] = fsc_pkg::ST_READY;
                    end
                    if (n_mode == fsc_pkg::M_CHAIN_PAIR && e[2] && !n_pr[2] &&
                        n_st[2] == fsc_pkg::ST_IDLE) begin
                        n_pr[2] = 1'b1;
                        n_st[2] = fsc_pkg::ST_READY;
                    end
                    for (int x = 1; x < 4; x++) begin
                        src_ok = 1'b1;
                        if (n_mode == fsc_pkg::M_CHAIN_ONE) begin
                            src = 2'd0;
                        end else if (n_mode == fsc_pkg::M_CHAIN_PAIR) begin
                            src    = (x == 1) ? 2'd0 : 2'd2;
                            src_ok = (x != 2);
                        end else begin
                            src = 2'(x - 1);
                        end
                        if (src_ok && n_pr[src] && n_en[x] && e[x] &&
                            n_st[x] == fsc_pkg::ST_IDLE) begin
                            n_st[x] = fsc_pkg::ST_READY;
                            if (n_mode == fsc_pkg::M_CHAIN_SER && x < 3)
                                n_pr[x] = 1'b1;
                        end
                    end
                    n_trig = i_req.trigger_in;
                end
                fsc_pkg::M_WINDOW: begin
                    n_gticks = tinc(n_gticks);
                    for (int x = 0; x < 4; x++) begin
                        if (e[x]) begin
                            n_time[x] = n_gticks;
                            n_pr[x]   = 1'b1;
                        end
                    end
                    n_trig = i_req.trigger_in;
                    if (n_pr == 4'hF) begin
                        for (int x = 0; x < 4; x++) begin
                            for (int z = x + 1; z < 4; z++) begin
                                d = (n_time[x] > n_time[z]) ? n_time[x] - n_time[z] :
                                                              n_time[z] - n_time[x];
                                if (d >= TW'(fsc_pkg::WINDOW_TICKS))
                                    ok = 1'b0;
                            end
                        end
                        if (ok) begin
                            if (n_win < 3'd4) begin
                                n_st[n_win[1:0]] = fsc_pkg::ST_READY;
                                n_win = n_win + 3'd1;
                            end
                            for (int x = 0; x < 4; x++)
                                n_time[x] = '0;
                            n_pr = 4'd0;
                        end
                    end
                end
                fsc_pkg::M_SERIES_A, fsc_pkg::M_SERIES_B, fsc_pkg::M_SERIES_C: begin
                    if (e[0] && !n_pr[0]) begin
                        n_st[0]   = fsc_pkg::ST_READY;
                        n_time[0] = '0;
                        n_pr[0]   = 1'b1;
                    end
                    if (n_pr[0]) begin
                        n_time[0] = tinc(n_time[0]);
                        for (int x = 1; x < 4; x++) begin
                            if (n_time[0] > TW'(fsc_pkg::series_at(n_mode[1:0], 2'(x - 1))) &&
                                n_st[x] == fsc_pkg::ST_IDLE) begin
                                n_st[x] = fsc_pkg::ST_READY;
                                if (x == 3)
                                    n_pr[0] = 1'b0;
                            end
                        end
                    end
                    n_trig[0] = i_req.trigger_in[0];
                end
                fsc_pkg::M_RELAY: begin
                    if (e[0] && !n_pr[0]) begin
                        n_st[0]   = fsc_pkg::ST_READY;
                        n_time[0] = '0;
                        n_pr[0]   = 1'b1;
                    end
                    if (n_pr[0]) begin
                        n_time[0] = tinc(n_time[0]);
                        if (n_en[1] && e[1] && !n_pr[1]) begin
                            n_st[1]   = fsc_pkg::ST_READY;
                            n_pr[1]   = 1'b1;
                            n_time[1] = n_time[0];
                            n_time[0] = '0;
                        end
                        if (n_pr[1] && n_st[2] == fsc_pkg::ST_IDLE && n_en[2] &&
                            n_time[0] > n_time[1])
                            n_st[2] = fsc_pkg::ST_READY;
                        if (n_pr[1] && n_st[3] == fsc_pkg::ST_IDLE && n_en[3] &&
                            {1'b0, n_time[0]} > {n_time[1], 1'b0})
                            n_st[3] = fsc_pkg::ST_READY;
                        n_trig[1] = i_req.trigger_in[1];
                    end
                    n_trig[0] = i_req.trigger_in[0];
                end
                fsc_pkg::M_MARK: begin
                    if (e[0] && !n_pr[0] && n_st[0] == fsc_pkg::ST_IDLE) begin
                        n_st[0]   = fsc_pkg::ST_READY;
                        n_time[0] = '0;
                        n_pr[0]   = 1'b1;
                    end
                    if (n_pr[0])
                        n_time[0] = tinc(n_time[0]);
                    for (int x = 1; x < 4; x++) begin
                        if (n_pr[0] && e[x] && !n_pr[x] && n_st[x] == fsc_pkg::ST_IDLE) begin
                            n_mark[x] = n_time[0];
                            n_pr[x]   = 1'b1;
                        end
                    end
                    for (int x = 1; x < 4; x++) begin
                        if (n_pr[0] && n_pr[x] && n_en[x] && n_st[x] == fsc_pkg::ST_IDLE &&
                            {1'b0, n_time[0]} > {n_mark[x], 1'b0})
                            n_st[x] = fsc_pkg::ST_READY;
                    end
                    n_trig = i_req.trigger_in;
                end
                fsc_pkg::M_SWEEP: begin
                    n_gticks = tinc(n_gticks);
                    for (int x = 0; x < 4; x++) begin
                        if (n_gticks >= TW'(fsc_pkg::sweep_at(2'(x))) &&
                            n_st[x] == fsc_pkg::ST_IDLE && !n_pr[x]) begin
                            n_st[x] = fsc_pkg::ST_READY;
                            n_pr[x] = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // ignition
        if (n_short) begin
            for (int x = 0; x < 4; x++) begin
                if (n_st[x] == fsc_pkg::ST_READY && n_en[x]) begin
                    n_pcnt[x] = 16'd0;
                    n_fire[x] = 1'b1;
                    n_st[x]   = fsc_pkg::ST_FIRE;
                end
                if (n_st[x] == fsc_pkg::ST_FIRE && n_en[x]) begin
                    n_pcnt[x] = n_pcnt[x] + 16'd1;
                    if (n_pcnt[x] == plen) begin
                        n_fire[x] = 1'b0;
                        n_en[x]   = 1'b0;
                        n_st[x]   = fsc_pkg::ST_IDLE;
                    end
                end
            end
        end else begin
            for (int x = 0; x < 4; x++) begin
                if (n_st[x] == fsc_pkg::ST_READY && n_en[x] && !n_q[x]) begin
                    if (n_idle) begin
                        n_pcnt[x] = 16'd0;
                        n_fire[x] = 1'b1;
                        n_st[x]   = fsc_pkg::ST_FIRE;
                        n_idle    = 1'b0;
                    end else begin
                        if (n_cnt < 3'd4) begin
                            n_tail         = n_tail + 2'd1;
                            n_cnt          = n_cnt + 3'd1;
                            n_fifo[n_tail] = 2'(x);
                        end
                        n_q[x] = 1'b1;
                    end
                end
            end
            // next queued channel once the line is free
            if (n_idle && n_cnt != 3'd0) begin
                y         = n_fifo[n_head];
                n_cnt     = n_cnt - 3'd1;
                n_head    = n_head + 2'd1;
                n_pcnt[y] = 16'd0;
                n_q[y]    = 1'b0;
                if (n_en[y]) begin
                    n_fire[y] = 1'b1;
                    n_st[y]   = fsc_pkg::ST_FIRE;
                    n_idle    = 1'b0;
                end
            end
            for (int x = 0; x < 4; x++) begin
                if (n_st[x] == fsc_pkg::ST_FIRE && n_en[x]) begin
                    n_pcnt[x] = n_pcnt[x] + 16'd1;
                    if (n_pcnt[x] == plen) begin
                        n_fire[x] = 1'b0;
                        n_en[x]   = 1'b0;
                        n_st[x]   = fsc_pkg::ST_IDLE;
                        n_idle    = 1'b1;
                    end
                end
            end
        end

        // every channel spent: disarm
        if (n_en == 4'd0)
            n_armed = 1'b0;
    end

    assign o_res.fire_out  = n_fire;
    assign o_res.led_out   = led;
    assign o_res.is_armed  = n_armed;
    assign o_res.mode_now  = n_mode;
    assign o_res.long_mode = ~n_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_last <= 1'b0;
            r_mode     <= fsc_pkg::M_EDGE;
            r_armed    <= 1'b0;
            r_press    <= 1'b0;
            r_rel_cnt  <= 16'd0;
            r_prs_cnt  <= 16'd0;
            r_short    <= 1'b0;
            r_fl_cnt   <= 16'd0;
            r_fl_ph    <= 1'b0;
            r_idle     <= 1'b1;
            r_win      <= 3'd0;
            r_gticks   <= '0;
            r_trig     <= 4'd0;
            r_en       <= 4'd0;
            r_pr       <= 4'd0;
            r_q        <= 4'd0;
            r_head     <= 2'd0;
            r_tail     <= 2'd3;
            r_cnt      <= 3'd0;
            r_fire     <= 4'd0;
            for (int x = 0; x < 4; x++) begin
                r_st[x]   <= fsc_pkg::ST_IDLE;
                r_time[x] <= '0;
                r_mark[x] <= '0;
                r_pcnt[x] <= 16'd0;
            end
        end else if (i_step) begin
            r_enc_last <= n_enc_last;
            r_mode     <= n_mode;
            r_armed    <= n_armed;
            r_press    <= n_press;
            r_rel_cnt  <= n_rel_cnt;
            r_prs_cnt  <= n_prs_cnt;
            r_short    <= n_short;
            r_fl_cnt   <= n_fl_cnt;
            r_fl_ph    <= n_fl_ph;
            r_idle     <= n_idle;
            r_win      <= n_win;
            r_gticks   <= n_gticks;
            r_trig     <= n_trig;
            r_en       <= n_en;
            r_pr       <= n_pr;
            r_q        <= n_q;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_cnt      <= n_cnt;
            r_fire     <= n_fire;
            for (int x = 0; x < 4; x++) begin
                r_st[x]   <= n_st[x];
                r_time[x] <= n_time[x];
                r_mark[x] <= n_mark[x];
                r_pcnt[x] <= n_pcnt[x];
            end
        end
    end

    // queue entries are written before they are read, so no reset
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int x = 0; x < 4; x++)
                r_fifo[x] <= n_fifo[x];
        end
    end

endmodule

[sv/four_channel_ignition_sequencer.sv]
`timescale 1ns / 1ps
// Top level of the four-channel ignition sequencer.
// Each request is one 5 ms tick of sampled encoder, button and trigger lines and
// yields one result: igniter drive, LED pattern, armed flag, mode and long-mode flag.
// A request is registered on entry, worked in one pass of logic against the
// sequencer state and its result registered on exit, so one request is taken
// every clock cycle unless a stalled result holds the next one in the input register.
// Configuration must be written by the user through the plain write port only
// while no request is in flight; the block itself does not enforce this.
module four_channel_ignition_sequencer #(
    parameter int TIME_WIDTH = fsc_pkg::TIME_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_enc_a,
    input  logic        i_enc_b,
    input  logic        i_button,
    input  logic [3:0]  i_trigger_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_fire_out,
    output logic [3:0]  o_led_out,
    output logic        o_is_armed,
    output logic [3:0]  o_mode_now,
    output logic        o_long_mode,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic          r_in_v;
    fsc_pkg::t_req r_in;
    logic          r_out_v;
    fsc_pkg::t_res r_out;
    fsc_pkg::t_res res;
    fsc_pkg::t_cfg r_cfg;
    logic          step;

    assign step       = r_in_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_in_v && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.enc_a      <= i_enc_a;
            r_in.enc_b      <= i_enc_b;
            r_in.button     <= i_button;
            r_in.trigger_in <= i_trigger_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks    <= 8'd20;
            r_cfg.long_press_ticks  <= 16'd300;
            r_cfg.short_pulse_ticks <= 16'd20;
            r_cfg.long_pulse_ticks  <= 16'd400;
            r_cfg.short_flash_ticks <= 16'd15;
            r_cfg.long_flash_ticks  <= 16'd120;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fsc_pkg::REG_DEBOUNCE:    r_cfg.debounce_ticks    <= i_cfg_data[7:0];
                fsc_pkg::REG_LONG_PRESS:  r_cfg.long_press_ticks  <= i_cfg_data;
                fsc_pkg::REG_SHORT_PULSE: r_cfg.short_pulse_ticks <= i_cfg_data;
                fsc_pkg::REG_LONG_PULSE:  r_cfg.long_pulse_ticks  <= i_cfg_data;
                fsc_pkg::REG_SHORT_FLASH: r_cfg.short_flash_ticks <= i_cfg_data;
                fsc_pkg::REG_LONG_FLASH:  r_cfg.long_flash_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fsc_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (step) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step)
            r_out <= res;
    end

    assign o_out_valid = r_out_v;
    assign o_fire_out  = r_out.fire_out;
    assign o_led_out   = r_out.led_out;
    assign o_is_armed  = r_out.is_armed;
    assign o_mode_now  = r_out.mode_now;
    assign o_long_mode = r_out.long_mode;

    // a channel only drives while armed
    a_fire_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out.is_armed |-> r_out.fire_out == 4'd0)
        else $error("igniter driven while disarmed");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_out.mode_now <= fsc_pkg::M_LAST)
        else $error("mode beyond last");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_v)
        else $error("worked request left no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && i_out_stall |-> !step)
        else $error("stalled result overwritten");

endmodule

[verif/tb_four_channel_ignition_sequencer.sv]
`timescale 1ns / 1ps
// Testbench for the four-channel ignition sequencer: directed and random ticks against a predictor.
module tb_four_channel_ignition_sequencer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_enc_a = 1'b0;
    logic        i_enc_b = 1'b0;
    logic        i_button = 1'b0;
    logic [3:0]  i_trigger_in = 4'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_fire_out;
    logic [3:0]  o_led_out;
    logic        o_is_armed;
    logic [3:0]  o_mode_now;
    logic        o_long_mode;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [15:0] i_cfg_data = 16'd0;

    four_channel_ignition_sequencer uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  c_deb;
    logic [15:0] c_lpress, c_spulse, c_lpulse, c_sflash, c_lflash;
    logic        s_enc_last, s_armed, s_press_on, s_short, s_phase, s_idle;
    logic [3:0]  s_mode, s_fire, s_tlast;
    logic [15:0] s_rel, s_press, s_flash;
    logic [2:0]  s_win, s_fcount;
    logic [31:0] s_gticks;
    logic [1:0]  s_fhead, s_ftail;
    logic [1:0]  s_fifo [4];
    fsc_pkg::t_chan_st s_cst [4];
    logic [3:0]  s_en, s_primed, s_queued;
    logic [31:0] s_ctime [4];
    logic [31:0] s_cmark [4];
    logic [15:0] s_pcnt [4];

    fsc_pkg::t_res results_due[$];
    int   fail_count = 0;
    int   tick_count = 0;
    bit   tx_calm = 0, rx_calm = 0;

    localparam logic [15:0] SERIES_OFS [3][3] = '{'{16'd400, 16'd800, 16'd1000},
        '{16'd800, 16'd1600, 16'd2400}, '{16'd2000, 16'd4000, 16'd6000}};

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] abs_gap(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void clear_channels();
        for (int x = 0; x < 4; x++) begin
            s_cst[x] = fsc_pkg::ST_IDLE;
            s_pcnt[x] = '0;
            s_ctime[x] = '0;
            s_cmark[x] = '0;
        end
        s_queued = '0; s_primed = '0; s_en = '0;
        s_fhead = 2'd0; s_ftail = 2'd3; s_fcount = '0;
        s_idle = 1'b1; s_win = '0; s_gticks = '0; s_fire = '0;
    endfunction

    function automatic void reset_predictor();
        c_deb = 8'd20; c_lpress = 16'd300; c_spulse = 16'd20;
        c_lpulse = 16'd400; c_sflash = 16'd15; c_lflash = 16'd120;
        s_enc_last = 0; s_mode = '0; s_armed = 0; s_press_on = 0; s_short = 0;
        s_phase = 0; s_rel = '0; s_press = '0; s_flash = '0; s_tlast = '0;
        for (int x = 0; x < 4; x++) s_fifo[x] = '0;
        clear_channels();
    endfunction

    function automatic void ignite(int x);
        s_pcnt[x] = '0;
        s_fire[x] = 1'b1;
        s_cst[x] = fsc_pkg::ST_FIRE;
    endfunction

    // one tick of a burning pulse; 1 when it has just ended
    function automatic bit pulse_done(int x, logic [15:0] len);
        if (s_cst[x] == fsc_pkg::ST_FIRE && s_en[x]) begin
            s_pcnt[x] = s_pcnt[x] + 16'd1;
            if (s_pcnt[x] == len) begin
                s_fire[x] = 1'b0;
                s_en[x] = 1'b0;
                s_cst[x] = fsc_pkg::ST_IDLE;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void trigger_logic(logic [3:0] p);
        logic [3:0]  e;
        logic [3:0]  m;
        logic [15:0] dly;
        logic [32:0] t0;
        bit          ok;
        int          src;
        e = p & ~s_tlast;
        m = s_mode;
        if (m == fsc_pkg::M_EDGE || m == fsc_pkg::M_COUNT) begin
            for (int x = 0; x < 4; x++) begin
                if (s_en[x] && e[x] && s_cst[x] == fsc_pkg::ST_IDLE) begin
                    if (m == fsc_pkg::M_EDGE) s_cst[x] = fsc_pkg::ST_READY;
                    else begin
                        s_ctime[x] = sat_inc(s_ctime[x]);
                        if (s_ctime[x] == fsc_pkg::COUNT_MATCH) s_cst[x] = fsc_pkg::ST_READY;
                    end
                end
            end
            s_tlast = p;
        end else if (m >= fsc_pkg::M_DELAY_A && m <= fsc_pkg::M_DELAY_C) begin
            dly = (m == fsc_pkg::M_DELAY_A) ? fsc_pkg::DELAY_A :
                  (m == fsc_pkg::M_DELAY_B) ? fsc_pkg::DELAY_B : fsc_pkg::DELAY_C;
            for (int x = 0; x < 4; x++) begin
                if (s_en[x] && e[x] && !s_primed[x]) begin
                    s_ctime[x] = '0;
                    s_primed[x] = 1;
                end
                if (s_primed[x] && s_en[x] && s_cst[x] == fsc_pkg::ST_IDLE) begin
                    s_ctime[x] = sat_inc(s_ctime[x]);
                    if (s_ctime[x] > dly) begin
                        s_cst[x] = fsc_pkg::ST_READY;
                        s_primed[x] = 0;
                    end
                end
            end
            s_tlast = p;
        end else if (m >= fsc_pkg::M_CHAIN_ONE && m <= fsc_pkg::M_CHAIN_SER) begin
            if (e[0] && !s_primed[0] && s_cst[0] == fsc_pkg::ST_IDLE) begin
                s_primed[0] = 1; s_cst[0] = fsc_pkg::ST_READY;
            end
            if (m == fsc_pkg::M_CHAIN_PAIR && e[2] && !s_primed[2] &&
                s_cst[2] == fsc_pkg::ST_IDLE) begin
                s_primed[2] = 1; s_cst[2] = fsc_pkg::ST_READY;
            end
            for (int x = 1; x < 4; x++) begin
                if (m == fsc_pkg::M_CHAIN_ONE) src = 0;
                else if (m == fsc_pkg::M_CHAIN_PAIR) src = (x == 1) ? 0 : (x == 3) ? 2 : -1;
                else src = x - 1;
                if (src >= 0 && s_primed[src] && s_en[x] && e[x] &&
                    s_cst[x] == fsc_pkg::ST_IDLE) begin
                    s_cst[x] = fsc_pkg::ST_READY;
                    if (m == fsc_pkg::M_CHAIN_SER && x < 3) s_primed[x] = 1;
                end
            end
            s_tlast = p;
        end else if (m == fsc_pkg::M_WINDOW) begin
            s_gticks = sat_inc(s_gticks);
            for (int x = 0; x < 4; x++)
                if (e[x]) begin
                    s_ctime[x] = s_gticks;
                    s_primed[x] = 1;
                end
            s_tlast = p;
            if (&s_primed) begin
                ok = 1;
                for (int x = 0; x < 4; x++)
                    for (int y = x + 1; y < 4; y++)
                        if (abs_gap(s_ctime[x], s_ctime[y]) >= fsc_pkg::WINDOW_TICKS) ok = 0;
                if (ok) begin
                    if (s_win < 3'd4) begin
                        s_cst[s_win[1:0]] = fsc_pkg::ST_READY;
                        s_win = s_win + 3'd1;
                    end
                    for (int x = 0; x < 4; x++) s_ctime[x] = '0;
                    s_primed = '0;
                end
            end
        end else if (m >= fsc_pkg::M_SERIES_A && m <= fsc_pkg::M_SERIES_C) begin
            if (e[0] && !s_primed[0]) begin
                s_cst[0] = fsc_pkg::ST_READY; s_ctime[0] = '0; s_primed[0] = 1;
            end
            if (s_primed[0]) begin
                s_ctime[0] = sat_inc(s_ctime[0]);
                for (int x = 1; x < 4; x++)
                    if (s_ctime[0] > SERIES_OFS[m - fsc_pkg::M_SERIES_A][x - 1] &&
                        s_cst[x] == fsc_pkg::ST_IDLE) begin
                        s_cst[x] = fsc_pkg::ST_READY;
                        if (x == 3) s_primed[0] = 0;
                    end
            end
            s_tlast[0] = p[0];
        end else if (m == fsc_pkg::M_RELAY) begin
            if (e[0] && !s_primed[0]) begin
                s_cst[0] = fsc_pkg::ST_READY; s_ctime[0] = '0; s_primed[0] = 1;
            end
            if (s_primed[0]) begin
                s_ctime[0] = sat_inc(s_ctime[0]);
                if (s_en[1] && e[1] && !s_primed[1]) begin
                    s_cst[1] = fsc_pkg::ST_READY; s_primed[1] = 1;
                    s_ctime[1] = s_ctime[0]; s_ctime[0] = '0;
                end
                t0 = {1'b0, s_ctime[0]};
                if (s_primed[1] && s_cst[2] == fsc_pkg::ST_IDLE && s_en[2] &&
                    t0 > {1'b0, s_ctime[1]})
                    s_cst[2] = fsc_pkg::ST_READY;
                if (s_primed[1] && s_cst[3] == fsc_pkg::ST_IDLE && s_en[3] &&
                    t0 > {s_ctime[1], 1'b0})
                    s_cst[3] = fsc_pkg::ST_READY;
                s_tlast[1] = p[1];
            end
            s_tlast[0] = p[0];
        end else if (m == fsc_pkg::M_MARK) begin
            if (e[0] && !s_primed[0] && s_cst[0] == fsc_pkg::ST_IDLE) begin
                s_cst[0] = fsc_pkg::ST_READY; s_ctime[0] = '0; s_primed[0] = 1;
            end
            if (s_primed[0]) s_ctime[0] = sat_inc(s_ctime[0]);
            for (int x = 1; x < 4; x++)
                if (s_primed[0] && e[x] && !s_primed[x] && s_cst[x] == fsc_pkg::ST_IDLE) begin
                    s_cmark[x] = s_ctime[0];
                    s_primed[x] = 1;
                end
            for (int x = 1; x < 4; x++)
                if (s_primed[0] && s_primed[x] && s_en[x] && s_cst[x] == fsc_pkg::ST_IDLE &&
                    {1'b0, s_ctime[0]} > {s_cmark[x], 1'b0})
                    s_cst[x] = fsc_pkg::ST_READY;
            s_tlast = p;
        end else if (m == fsc_pkg::M_SWEEP) begin
            s_gticks = sat_inc(s_gticks);
            for (int x = 0; x < 4; x++)
                if (s_gticks >= 32'd2000 * (x + 1) && s_cst[x] == fsc_pkg::ST_IDLE &&
                    !s_primed[x]) begin
                    s_cst[x] = fsc_pkg::ST_READY;
                    s_primed[x] = 1;
                end
        end
    endfunction

    function automatic fsc_pkg::t_res predict_tick(logic a, logic b, logic btn, logic [3:0] p);
        fsc_pkg::t_res r;
        logic [15:0] plen, flen;
        logic [3:0]  led, mp1;
        int          y;
        if (!s_armed) begin
            if (s_enc_last && !a) begin
                if (b != a) s_mode = (s_mode >= 4'd14) ? 4'd0 : s_mode + 4'd1;
                else s_mode = (s_mode == 4'd0 || s_mode > 4'd14) ? 4'd14 : s_mode - 4'd1;
            end
            s_enc_last = a;
        end
        if (btn && s_rel > c_deb) begin
            s_press_on = 1; s_rel = '0;
        end
        if (s_press_on && s_press != 16'hFFFF) s_press++;
        if (s_press_on && s_rel > c_deb) begin
            s_rel = '0; s_press_on = 0; s_armed = ~s_armed;
            if (s_armed) begin
                s_en = 4'hF;
                s_short = !(s_press > c_lpress);
            end
            s_press = '0;
        end
        if (!s_armed) clear_channels();
        if (!btn && s_rel != 16'hFFFF) s_rel++;

        plen = s_short ? c_spulse : c_lpulse;
        flen = s_short ? c_sflash : c_lflash;
        mp1 = s_mode + 4'd1;
        led = (s_mode == 4'd15) ? 4'd0 : {mp1[0], mp1[1], mp1[2], mp1[3]};
        if (s_armed) begin
            if (s_flash != 16'hFFFF) s_flash++;
            if (s_flash > flen) begin
                s_phase = ~s_phase; s_flash = '0;
            end
            if (!s_phase) led = 4'd0;
            trigger_logic(p);
        end

        if (s_short) begin
            for (int x = 0; x < 4; x++) begin
                if (s_cst[x] == fsc_pkg::ST_READY && s_en[x]) ignite(x);
                void'(pulse_done(x, plen));
            end
        end else begin
            for (int x = 0; x < 4; x++)
                if (s_cst[x] == fsc_pkg::ST_READY && s_en[x] && !s_queued[x]) begin
                    if (s_idle) begin
                        ignite(x); s_idle = 0;
                    end else begin
                        if (s_fcount < 3'd4) begin
                            s_ftail = s_ftail + 2'd1;
                            s_fcount++;
                            s_fifo[s_ftail] = x[1:0];
                        end
                        s_queued[x] = 1;
                    end
                end
            if (s_idle && s_fcount > 0) begin
                y = s_fifo[s_fhead];
                s_fcount--;
                s_fhead = s_fhead + 2'd1;
                s_pcnt[y] = '0;
                s_queued[y] = 0;
                if (s_en[y]) begin
                    ignite(y); s_idle = 0;
                end
            end
            for (int x = 0; x < 4; x++)
                if (pulse_done(x, plen)) s_idle = 1;
        end
        if (s_en == 4'd0) s_armed = 0;

        r.fire_out = s_fire;
        r.led_out = led;
        r.is_armed = s_armed;
        r.mode_now = s_mode;
        r.long_mode = !s_short;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // sends one request and records the outcome it should give
    task automatic send_tick(logic a, logic b, logic btn, logic [3:0] trig);
        int  gap;
        bit  st;
        if ($urandom_range(0, 40) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_enc_a <= a; i_enc_b <= b; i_button <= btn; i_trigger_in <= trig;
        do begin
            @(negedge i_clk);
            st = o_in_stall;
            @(posedge i_clk);
        end while (st);
        results_due.push_back(predict_tick(a, b, btn, trig));
        tick_count++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            fsc_pkg::REG_DEBOUNCE:    c_deb = val[7:0];
            fsc_pkg::REG_LONG_PRESS:  c_lpress = val;
            fsc_pkg::REG_SHORT_PULSE: c_spulse = val;
            fsc_pkg::REG_LONG_PULSE:  c_lpulse = val;
            fsc_pkg::REG_SHORT_FLASH: c_sflash = val;
            fsc_pkg::REG_LONG_FLASH:  c_lflash = val;
            default: ;
        endcase
    endtask

    function automatic logic [3:0] rand_trig();
        return 4'($urandom_range(0, 15));
    endfunction

    // full debounced press: settle, hold, release long enough to count
    task automatic press_button(int hold);
        repeat (int'(c_deb) + 1) send_tick($urandom_range(0, 1), $urandom_range(0, 1), 0, rand_trig());
        repeat (hold) send_tick($urandom_range(0, 1), $urandom_range(0, 1), 1, rand_trig());
        repeat (int'(c_deb) + 2) send_tick($urandom_range(0, 1), $urandom_range(0, 1), 0, rand_trig());
    endtask

    task automatic select_mode(logic [3:0] target);
        logic dir;
        int   n;
        dir = $urandom_range(0, 1);
        n = 0;
        while (s_mode != target && !s_armed && n < 20) begin
            send_tick(1, $urandom_range(0, 1), 0, rand_trig());
            send_tick(0, dir, 0, rand_trig());
            n++;
        end
    endtask

    task automatic test_encoder_and_registers();
        // step up, step down, down across the wrap to 14, then up from 14 to 0
        send_tick(1, 0, 0, 4'hF);
        send_tick(0, 1, 0, 4'h0);
        send_tick(1, 1, 0, 4'hF);
        send_tick(0, 0, 0, 4'h0);
        send_tick(0, 0, 0, 4'h5);
        send_tick(1, 0, 0, 4'hA);
        send_tick(0, 0, 0, 4'h0);
        send_tick(1, 0, 0, 4'h0);
        send_tick(0, 1, 0, 4'h0);
        // a press shorter than debounce must not arm
        send_tick(0, 0, 1, 4'h0);
        send_tick(0, 0, 0, 4'h0);
        write_reg(fsc_pkg::REG_DEBOUNCE, 16'd255);
        write_reg(fsc_pkg::REG_LONG_PRESS, 16'hFFFF);
        write_reg(fsc_pkg::REG_SHORT_PULSE, 16'd1);
        write_reg(fsc_pkg::REG_LONG_PULSE, 16'hFFFF);
        write_reg(fsc_pkg::REG_SHORT_FLASH, 16'd0);
        write_reg(fsc_pkg::REG_LONG_FLASH, 16'hFFFF);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h5A5A);
        repeat (6) send_tick($urandom_range(0, 1), $urandom_range(0, 1), 1, rand_trig());
        write_reg(fsc_pkg::REG_DEBOUNCE, 16'd0);
        write_reg(fsc_pkg::REG_LONG_PRESS, 16'd0);
        // with debounce 0 and long press 0 every press that arms selects long mode
        press_button(2);
        repeat (4) send_tick(0, 0, 0, 4'hF);
        press_button(1);
    endtask

    task automatic randomise_registers();
        int k;
        k = $urandom_range(0, 9);
        write_reg(fsc_pkg::REG_DEBOUNCE, 16'($urandom_range(0, 3)));
        write_reg(fsc_pkg::REG_LONG_PRESS,
                  (k == 0) ? 16'hFFFF : (k == 1) ? 16'd0 : 16'($urandom_range(1, 12)));
        write_reg(fsc_pkg::REG_SHORT_PULSE, (k == 2) ? 16'd1 : 16'($urandom_range(1, 30)));
        write_reg(fsc_pkg::REG_LONG_PULSE, (k == 3) ? 16'd1 : 16'($urandom_range(2, 25)));
        write_reg(fsc_pkg::REG_SHORT_FLASH, (k == 4) ? 16'hFFFF : 16'($urandom_range(0, 20)));
        write_reg(fsc_pkg::REG_LONG_FLASH, (k == 5) ? 16'd0 : 16'($urandom_range(0, 20)));
    endtask

    // arm in a chosen mode, then drive trigger activity
    task automatic test_firing_episodes(int budget);
        int         ep, len, stop, hold;
        logic [3:0] trig, tmode;
        ep = 0;
        stop = tick_count + budget;
        while (tick_count < stop) begin
            if (ep % 3 == 0) randomise_registers();
            tmode = (ep < 30) ? 4'(ep % 15) : 4'($urandom_range(0, 14));
            if (s_armed) press_button(1);
            select_mode(tmode);
            // a long hold only where the threshold is small enough to reach
            hold = (c_lpress < 16'd40 && $urandom_range(0, 3) == 0) ?
                   int'(c_lpress) + 2 : $urandom_range(1, 3);
            press_button(hold);
            len = (tmode >= fsc_pkg::M_DELAY_A && tmode <= fsc_pkg::M_DELAY_C) ||
                  tmode == fsc_pkg::M_SWEEP ||
                  (tmode >= fsc_pkg::M_SERIES_A && tmode <= fsc_pkg::M_RELAY) ?
                  $urandom_range(60, 260) : $urandom_range(15, 80);
            if (len > stop - tick_count)
                len = (stop - tick_count > 1) ? stop - tick_count : 1;
            trig = '0;
            for (int i = 0; i < len; i++) begin
                // mostly sparse edges, some noise
                if ($urandom_range(0, 3) == 0) trig = rand_trig();
                else if ($urandom_range(0, 1) == 0) trig = '0;
                send_tick($urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 60) == 0, trig);
            end
            ep++;
        end
    endtask

    // result side: random stall before each result, checked on acceptance
    initial begin
        int   w;
        bit   v;
        fsc_pkg::t_res got, want;
        forever begin
            if ($urandom_range(0, 40) == 0) rx_calm = !rx_calm;
            w = rx_calm ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do begin
                @(negedge i_clk);
                v = o_out_valid && i_rst_n;
                got = '{o_fire_out, o_led_out, o_is_armed, o_mode_now, o_long_mode};
                @(posedge i_clk);
            end while (!v);
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = results_due.pop_front();
                if (got.fire_out !== want.fire_out)
                    report_mismatch("fire_out", got.fire_out, want.fire_out);
                if (got.led_out !== want.led_out)
                    report_mismatch("led_out", got.led_out, want.led_out);
                if (got.is_armed !== want.is_armed)
                    report_mismatch("is_armed", got.is_armed, want.is_armed);
                if (got.mode_now !== want.mode_now)
                    report_mismatch("mode_now", got.mode_now, want.mode_now);
                if (got.long_mode !== want.long_mode)
                    report_mismatch("long_mode", got.long_mode, want.long_mode);
            end
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        reset_predictor();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_encoder_and_registers();
        test_firing_episodes(1320);
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
